// ===== design/cla_pkg.sv =====
package cla_pkg;

  localparam int MAX_LINE_DEF = 512;
  localparam int MAX_CHUNK    = 20;
  localparam int CNT_W        = 5;
  localparam int LANES        = 32;
  localparam int LANE_W       = 5;
  localparam int WORD_W       = 6;
  localparam int LEN_W_DEF    = $clog2(MAX_LINE_DEF + 1);

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
  localparam logic [7:0]  NEWLINE       = 8'h0A;
  localparam logic [7:0]  SCAN_CHAR     = 8'h58;
  localparam logic [7:0]  NUL_CHAR      = 8'h00;

  typedef logic [7:0] byte_t;
  typedef logic [MAX_CHUNK-1:0][7:0] chunk_t;

  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_PROTO    = 3'd5
  } status_t;

  // chunk write broadcast to the byte lanes
  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] count;
    chunk_t           data;
  } wr_t;

  // result beat waiting for the read merge
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic              disc;
    logic              rd;
    logic [WORD_W-1:0] word;
  } res_t;

  // row address bits of one byte lane bank
  function automatic int row_bits(int max_line);
    int rows;
    rows = (max_line + LANES - 1) >> LANE_W;
    return (rows > 1) ? $clog2(rows) : 1;
  endfunction

endpackage

// ===== design/cla_if.sv =====
interface cla_req_if import cla_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [CNT_W-1:0] chunk_length;
  logic [63:0]      bytes_low;
  logic [63:0]      bytes_mid;
  logic [31:0]      bytes_high;
  logic [31:0]      now_time;
  logic [WORD_W-1:0] word_index;

  modport source (output valid, operation, chunk_length, bytes_low, bytes_mid, bytes_high,
                  now_time, word_index, input ready);
  modport sink   (input valid, operation, chunk_length, bytes_low, bytes_mid, bytes_high,
                  now_time, word_index, output ready);
endinterface

interface cla_rsp_if import cla_pkg::*; #(parameter int LEN_W = LEN_W_DEF);
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [LEN_W-1:0] line_length;
  logic             discarding;
  logic [63:0]      read_data;

  modport source (output valid, status, line_length, discarding, read_data, input ready);
  modport sink   (input valid, status, line_length, discarding, read_data, output ready);
endinterface

interface cla_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/cla_lane.sv =====
module cla_lane import cla_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF,
  parameter int LANE     = 0
) (
  input  logic                      clk,
  input  wr_t                       wr,
  input  logic [LANE_W+row_bits(MAX_LINE)-1:0] wr_base,
  input  logic                      rd_en,
  input  logic [row_bits(MAX_LINE)-1:0] rd_row,
  output byte_t                     rd_byte
);

  localparam int ROWS  = (MAX_LINE + LANES - 1) / LANES;
  localparam int ROW_W = row_bits(MAX_LINE);
  localparam int PW    = LANE_W + ROW_W;

  byte_t mem [ROWS];

  logic [LANE_W-1:0] idx;
  logic [PW-1:0]     pos;
  logic              act;
  byte_t             wbyte;

  // chunk byte that lands in this lane, relative to the line fill point
  always_comb begin
    idx   = LANE_W'(LANE) - wr_base[LANE_W-1:0];
    pos   = wr_base + PW'(idx);
    act   = wr.en && (idx < wr.count);
    wbyte = (idx < LANE_W'(MAX_CHUNK)) ? wr.data[idx] : NUL_CHAR;
  end

  always_ff @(posedge clk) begin
    if (act) begin
      mem[pos[PW-1:LANE_W]] <= wbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_byte <= mem[rd_row];
    end
  end

endmodule

// ===== design/cla_ctrl.sv =====
module cla_ctrl import cla_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  cla_req_if.sink                   req,
  cla_cfg_if.sink                   cfg,
  input  logic                      s2_ready,
  output res_t                      s2,
  output logic [$clog2(MAX_LINE+1)-1:0] s2_len,
  output wr_t                       wr,
  output logic [LANE_W+row_bits(MAX_LINE)-1:0] wr_base,
  output logic                      rd_en,
  output logic [row_bits(MAX_LINE)-1:0] rd_row
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int ROW_W = row_bits(MAX_LINE);
  localparam int PW    = LANE_W + ROW_W;

  // input stage
  logic              s1_v;
  op_t               s1_op;
  logic [CNT_W-1:0]  s1_n;
  chunk_t            s1_bytes;
  logic [31:0]       s1_now;
  logic [WORD_W-1:0] s1_word;
  logic              s1_len_ok;
  logic              s1_has_nl;
  logic              s1_err;
  logic              s1_last_nl;
  logic              s1_is_x;

  // receiver state
  logic [LEN_W-1:0]  held;
  logic              disc;
  logic [31:0]       start;
  logic [31:0]       tmo;

  logic [LEN_W-1:0]  held_next;
  logic              disc_next;
  logic [31:0]       start_next;

  chunk_t            in_b;
  logic              in_nl;
  logic              in_err;
  logic              in_last;
  logic              req_fire;
  logic              s1_adv;
  logic              s2_adv;

  status_t           ex_status;
  logic              ex_wr;
  logic              ex_rd;
  logic              active;
  logic              expired;
  logic [31:0]       age;
  logic [LEN_W:0]    sum;

  assign cfg.ready = 1'b1;
  assign s2_adv    = s2.valid && s2_ready;
  assign s1_adv    = s1_v && (!s2.valid || s2_adv);
  assign req.ready = !s1_v || s1_adv;
  assign req_fire  = req.valid && req.ready;

  // byte scan on the incoming beat, in chunk order
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      in_b[i]     = req.bytes_low[8*i +: 8];
      in_b[8 + i] = req.bytes_mid[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      in_b[16 + i] = req.bytes_high[8*i +: 8];
    end
    in_nl   = 1'b0;
    in_err  = 1'b0;
    in_last = 1'b0;
    for (int i = 0; i < MAX_CHUNK; i++) begin
      if (CNT_W'(i) < req.chunk_length) begin
        if (in_b[i] == NEWLINE) begin
          in_nl = 1'b1;
        end
        if (in_b[i] == NUL_CHAR ||
            (in_b[i] == NEWLINE && CNT_W'(i) != req.chunk_length - CNT_W'(1))) begin
          in_err = 1'b1;
        end
        if (in_b[i] == NEWLINE && CNT_W'(i) == req.chunk_length - CNT_W'(1)) begin
          in_last = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_op      <= op_t'(req.operation);
      s1_n       <= req.chunk_length;
      s1_bytes   <= in_b;
      s1_now     <= req.now_time;
      s1_word    <= req.word_index;
      s1_len_ok  <= (req.chunk_length != '0) &&
                    (req.chunk_length <= CNT_W'(MAX_CHUNK));
      s1_has_nl  <= in_nl;
      s1_err     <= in_err;
      s1_last_nl <= in_last;
      s1_is_x    <= (req.chunk_length == CNT_W'(1)) && (in_b[0] == SCAN_CHAR);
    end
  end

  // one step of the receiver per beat
  always_comb begin
    held_next  = held;
    disc_next  = disc;
    start_next = start;
    ex_status  = ST_OK;
    ex_wr      = 1'b0;
    ex_rd      = 1'b0;
    active     = (held != '0) || disc;
    age        = s1_now - start;
    expired    = active && (age >= tmo);
    sum        = (LEN_W+1)'(held) + (LEN_W+1)'(s1_n);
    unique case (s1_op)
      OP_FEED: begin
        if (!s1_len_ok) begin
          ex_status = ST_BAD_LEN;
        end else if (expired) begin
          held_next  = '0;
          disc_next  = 1'b0;
          start_next = '0;
          ex_status  = ST_TIMEOUT;
        end else begin
          if (!active) begin
            start_next = s1_now;
          end
          if (disc) begin
            ex_status = ST_TOO_LONG;
            if (s1_has_nl) begin
              held_next  = '0;
              disc_next  = 1'b0;
              start_next = '0;
            end
          end else if (sum > (LEN_W+1)'(MAX_LINE)) begin
            held_next = '0;
            disc_next = 1'b1;
            ex_status = ST_TOO_LONG;
          end else if (s1_err) begin
            held_next  = '0;
            disc_next  = 1'b0;
            start_next = '0;
            ex_status  = ST_PROTO;
          end else begin
            ex_wr     = 1'b1;
            held_next = sum[LEN_W-1:0];
            // a lone X on an empty line counts as a full line
            ex_status = (s1_last_nl || (held == '0 && s1_is_x)) ? ST_COMPLETE : ST_OK;
          end
        end
      end
      OP_CLEAR: begin
        held_next  = '0;
        disc_next  = 1'b0;
        start_next = '0;
      end
      OP_READ: begin
        ex_rd = 1'b1;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  assign wr.en    = ex_wr && s1_adv && s1_v;
  assign wr.count = s1_n;
  assign wr.data  = s1_bytes;
  assign wr_base  = PW'(held);
  assign rd_en    = ex_rd && s1_adv;
  assign rd_row   = ROW_W'(s1_word[WORD_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v     <= 1'b0;
      s2.valid <= 1'b0;
      held     <= '0;
      disc     <= 1'b0;
      start    <= '0;
      tmo      <= TIMEOUT_RESET;
    end else begin
      if (req_fire) begin
        s1_v <= 1'b1;
      end else if (s1_adv) begin
        s1_v <= 1'b0;
      end
      if (s1_adv) begin
        s2.valid <= 1'b1;
        held     <= held_next;
        disc     <= disc_next;
        start    <= start_next;
      end else if (s2_adv) begin
        s2.valid <= 1'b0;
      end
      if (cfg.valid) begin
        tmo <= cfg.data;
      end
    end
    if (s1_adv) begin
      s2.status <= ex_status;
      s2.disc   <= disc_next;
      s2.rd     <= ex_rd;
      s2.word   <= s1_word;
      s2_len    <= held_next;
    end
  end

`ifndef ASSERT_OFF
  a_disc_empty: assert property (@(posedge clk) disable iff (rst)
    disc |-> (held == '0))
    else $error("discard mode with a held line");

  a_wr_feed: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (!disc && s1_op == OP_FEED && s1_len_ok))
    else $error("store write outside an appending feed");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_op == OP_CLEAR) |=> (held == '0 && !disc && start == '0))
    else $error("clear left receiver state behind");

  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2.valid && !s2_ready) |=> (s2.valid && $stable(s2_len) && $stable(s2.status)))
    else $error("stalled result changed");
`endif

endmodule

// ===== design/cla_merge.sv =====
module cla_merge import cla_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  res_t                      s2,
  input  logic [$clog2(MAX_LINE+1)-1:0] s2_len,
  input  logic [LANES-1:0][7:0]     lane_rd,
  output logic                      s2_ready,
  cla_rsp_if.source                 rsp
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int PW    = WORD_W + 3;
  localparam int CW    = (LEN_W > PW) ? LEN_W : PW;

  logic                 out_v;
  status_t              out_status;
  logic [LEN_W-1:0]     out_len;
  logic                 out_disc;
  logic [63:0]          out_data;
  logic [63:0]          word_data;
  logic [PW-1:0]        pos;
  logic [LANE_W-1:0]    lane;

  assign s2_ready = !out_v || rsp.ready;

  // pick the eight lanes of the word and blank bytes past the line end
  always_comb begin
    word_data = '0;
    pos       = '0;
    lane      = '0;
    for (int k = 0; k < 8; k++) begin
      pos  = {s2.word, 3'(k)};
      lane = {s2.word[1:0], 3'(k)};
      if (s2.rd && (CW'(pos) < CW'(s2_len))) begin
        word_data[8*k +: 8] = lane_rd[lane];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (s2.valid && s2_ready) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid && s2_ready) begin
      out_status <= s2.status;
      out_len    <= s2_len;
      out_disc   <= s2.disc;
      out_data   <= word_data;
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.status      = out_status;
  assign rsp.line_length = out_len;
  assign rsp.discarding  = out_disc;
  assign rsp.read_data   = out_data;

`ifndef ASSERT_OFF
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (s2.valid && s2_ready && !s2.rd) |=> (out_data == '0))
    else $error("read data on a beat that is not a read");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_v && !rsp.ready) |=> (out_v && $stable(out_data) && $stable(out_len)))
    else $error("output beat changed while stalled");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_len <= LEN_W'(MAX_LINE)))
    else $error("line length beyond store");
`endif

endmodule

// ===== design/command_line_assembler_unit.sv =====
// Command line assembler. Feed beats carry link chunks of 1 to 20 bytes that
// are appended to a line store until a chunk ends in a newline; clear and read
// beats empty the receiver or return eight stored bytes (zero past the line
// length). One beat is taken per cycle while the output is not stalled, and every
// beat's result beat passes through an input register loaded on acceptance,
// the receiver state update with the store write or read, and the output
// register that merges the eight read lanes. The store is split into 32
// byte-wide banks, one per byte lane, so a whole chunk is written in the same
// cycle at any fill point. The store needs no clearing after reset; the
// timeout register is to be written through cfg only while the block is idle,
// which the block itself does not enforce.
module command_line_assembler_unit import cla_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input logic       clk,
  input logic       rst,
  cla_cfg_if.sink   cfg,
  cla_req_if.sink   req,
  cla_rsp_if.source rsp
);

  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int ROW_W = row_bits(MAX_LINE);
  localparam int PW    = LANE_W + ROW_W;

  res_t                   s2;
  logic [LEN_W-1:0]       s2_len;
  logic                   s2_ready;
  wr_t                    wr;
  logic [PW-1:0]          wr_base;
  logic                   rd_en;
  logic [ROW_W-1:0]       rd_row;
  logic [LANES-1:0][7:0]  lane_rd;

  cla_ctrl #(.MAX_LINE(MAX_LINE)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .s2_ready (s2_ready),
    .s2       (s2),
    .s2_len   (s2_len),
    .wr       (wr),
    .wr_base  (wr_base),
    .rd_en    (rd_en),
    .rd_row   (rd_row)
  );

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    cla_lane #(.MAX_LINE(MAX_LINE), .LANE(j)) u_lane (
      .clk     (clk),
      .wr      (wr),
      .wr_base (wr_base),
      .rd_en   (rd_en),
      .rd_row  (rd_row),
      .rd_byte (lane_rd[j])
    );
  end

  cla_merge #(.MAX_LINE(MAX_LINE)) u_merge (
    .clk      (clk),
    .rst      (rst),
    .s2       (s2),
    .s2_len   (s2_len),
    .lane_rd  (lane_rd),
    .s2_ready (s2_ready),
    .rsp      (rsp)
  );

endmodule
